// ----- rtl/i2dt_pkg.sv -----
// Shared types and constants for the int16_to_decimal_text block.
// Used by the front, queue, back and top-level modules.
package i2dt_pkg;

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [2:0] LAST_PLACE = 3'd4;

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } i2dt_item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } i2dt_qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } i2dt_bk_state_t;

  function automatic logic [16:0] digit_weight(input logic [2:0] place, input logic [3:0] d);
    int base;
    case (place)
      3'd0:    base = 10000;
      3'd1:    base = 1000;
      3'd2:    base = 100;
      3'd3:    base = 10;
      default: base = 1;
    endcase
    return 17'(base * int'(d));
  endfunction

endpackage

// ----- rtl/i2dt_front.sv -----
// Front end: accepts input values, holds the missing-value register and
// classifies each value into sign and magnitude. Depends on i2dt_pkg.
module i2dt_front
  import i2dt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // [15:0] missing_code
  input  i2dt_qstat_t q_stat,
  output logic        push,
  output i2dt_item_t  push_item
);

  logic [15:0] missing_r;
  logic [15:0] missing_nxt;
  logic        drop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;

  always_comb begin
    missing_nxt = missing_r;
    if (cfg_valid && cfg_ready) begin
      missing_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_r <= 16'h8000;
    end else begin
      missing_r <= missing_nxt;
    end
  end

  assign drop           = (in_tdata != 16'd0) && (in_tdata == missing_r);
  assign push           = in_tvalid && in_tready && !drop;
  assign push_item.neg  = in_tdata[15];
  assign push_item.mag  = in_tdata[15] ? 16'(-in_tdata) : in_tdata;

endmodule

// ----- rtl/i2dt_queue.sv -----
// Two-entry queue of classified values between front and back.
// Depends on i2dt_pkg.
module i2dt_queue
  import i2dt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  i2dt_item_t  push_item,
  input  logic        pop,
  output i2dt_item_t  pop_item,
  output i2dt_qstat_t stat
);

  i2dt_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

// ----- rtl/i2dt_back.sv -----
// Back end: turns one queued value into characters, one decimal place per
// cycle unless output stalls, into an output register. Depends on i2dt_pkg.
module i2dt_back
  import i2dt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  i2dt_qstat_t q_stat,
  input  i2dt_item_t  q_item,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] character
  output logic        out_tlast   // last
);

  i2dt_bk_state_t    state_r, state_nxt;
  logic [15:0]       mag_r, mag_nxt;
  logic [2:0]        place_r, place_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              advance;
  logic              emit;
  logic              do_load;
  logic [3:0]        digit;
  logic [15:0]       weight;
  logic [15:0]       rem;

  always_comb begin
    digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, mag_r} >= digit_weight(place_r, 4'(k))) begin
        digit = 4'(k);
      end
    end
    weight = 16'(digit_weight(place_r, digit));
    rem    = mag_r - weight;
  end

  assign advance = !out_valid_r || out_tready;
  assign emit    = (digit != 4'd0) || started_r || (place_r == LAST_PLACE);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    place_nxt     = place_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    do_load       = 1'b0;
    pop           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        do_load = !q_stat.empty;
      end
      BK_SIGN: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        if (!emit || advance) begin
          mag_nxt     = rem;
          started_nxt = started_r | emit;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CH_ZERO + {2'b00, digit};
            out_last_nxt  = (place_r == LAST_PLACE);
          end
          if (place_r == LAST_PLACE) begin
            state_nxt = BK_IDLE;
            do_load   = !q_stat.empty;
          end else begin
            place_nxt = place_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (do_load) begin
      pop         = 1'b1;
      mag_nxt     = q_item.mag;
      place_nxt   = 3'd0;
      started_nxt = 1'b0;
      state_nxt   = q_item.neg ? BK_SIGN : BK_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      place_r     <= 3'd0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      place_r     <= place_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/int16_to_decimal_text.sv -----
// Signed 16-bit to decimal ASCII text: one character per output transaction,
// most significant first, tlast on the final one. The back end emits the '-'
// if the value is negative, then steps through the five decimal places in
// order (ten-thousands down to units), waiting while the output stalls. It
// loads the next value as it handles the units place if the queue holds one;
// a value that reaches an idle back end is loaded from the idle state first.
// Values equal to a nonzero missing_code are dropped at the front and never
// reach the back end. A two-entry queue lets input keep flowing while the
// back end or the output stalls. Built from i2dt_front, i2dt_queue, i2dt_back
// and i2dt_pkg.
module int16_to_decimal_text
  import i2dt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] character
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // [15:0] missing_code
);

  i2dt_qstat_t q_stat;
  i2dt_item_t  push_item;
  i2dt_item_t  pop_item;
  logic        push;
  logic        pop;

  i2dt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  i2dt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  i2dt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_item     (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_minus_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tlast && (out_tdata[5:0] == CH_MINUS)))
    else $error("minus sign marked as last character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] == CH_MINUS) ||
                   ((out_tdata[5:0] >= CH_ZERO) && (out_tdata[5:0] <= CH_ZERO + 6'd9)))
    else $error("output character out of range");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= 2'd2)
    else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule
